/* design/psvm_pkg.sv */
package psvm_pkg;

  localparam logic [1:0] FUNC_LOAD    = 2'd0;
  localparam logic [1:0] FUNC_TRIGGER = 2'd1;
  localparam logic [1:0] FUNC_TICK    = 2'd2;
  localparam logic [1:0] FUNC_UNUSED  = 2'd3;

  localparam logic [2:0] REG_MASTER = 3'd0;
  localparam logic [2:0] REG_STEREO = 3'd1;
  localparam logic [2:0] REG_LEN0   = 3'd2;
  localparam int LEN_REGS = 5;

  localparam logic [15:0] GAIN_BASE = 16'd13107;
  localparam logic [14:0] GAIN_SPAN = 15'd19661;

  // Item handed from the front part to the back part.
  typedef struct packed {
    logic [1:0]  func;
    logic [2:0]  pad;
    logic [7:0]  velocity;
    logic [12:0] sample_address;
    logic [15:0] sample_value;
  } item_t;

endpackage

/* design/psvm_front.sv */
module psvm_front #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  psvm_pkg::item_t   in_item,
  output logic              q_valid,
  input  logic              q_ready,
  output psvm_pkg::item_t   q_item
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  psvm_pkg::item_t mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;
  logic          keep;

  // Unused function codes are dropped here and never reach the back part.
  assign keep     = (in_item.func != psvm_pkg::FUNC_UNUSED);
  assign in_ready = (cnt_r != (AW+1)'(DEPTH));
  assign q_valid  = (cnt_r != '0);
  assign q_item   = mem_r[rp_r];

  logic push, pop;
  assign push = in_valid && in_ready && keep;
  assign pop  = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= in_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + AW'(1);
      if (pop)  rp_r <= (rp_r == AW'(DEPTH-1)) ? '0 : rp_r + AW'(1);
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

endmodule

/* design/psvm_back.sv */
module psvm_back #(
  parameter int VOICES      = 16,
  parameter int PADS        = 5,
  parameter int QUEUE_DEPTH = 64,
  parameter int PAD_SAMPLES = 8192
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  output logic             q_ready,
  input  psvm_pkg::item_t  q_item,
  input  logic [15:0]      master_gain,
  input  logic             stereo_mode,
  input  logic [13:0]      pad_len [psvm_pkg::LEN_REGS],
  output logic             out_valid,
  input  logic             out_ready,
  output logic [15:0]      o_left,
  output logic [15:0]      o_right,
  output logic [4:0]       o_active,
  output logic [31:0]      o_dropped
);

  localparam int VW  = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int QW  = $clog2(QUEUE_DEPTH);
  localparam int SW  = $clog2(PAD_SAMPLES);
  localparam int MW  = $clog2(PADS * PAD_SAMPLES);
  localparam int CW  = $clog2(VOICES + 1);
  localparam int POW = SW + 1;

  localparam logic [22:0] GAIN_SPAN_EXT = 23'(psvm_pkg::GAIN_SPAN);
  // ceil(2^31 / 255); exact floor division for every gain product.
  localparam logic [23:0] RECIP_255 = 24'd8421505;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DRAIN = 4'd1;
  localparam logic [3:0] S_TRIG  = 4'd2;
  localparam logic [3:0] S_FIND  = 4'd3;
  localparam logic [3:0] S_VOICE = 4'd4;
  localparam logic [3:0] S_RD    = 4'd5;
  localparam logic [3:0] S_MUL1  = 4'd6;
  localparam logic [3:0] S_MUL2  = 4'd7;
  localparam logic [3:0] S_ACC   = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;
  localparam logic [3:0] S_GAIN  = 4'd10;

  logic [3:0] st_r;

  logic [15:0] smem [PADS * PAD_SAMPLES];
  logic [15:0] srd_r;
  logic [10:0] tq [QUEUE_DEPTH];
  logic [10:0] tq_rd_r;
  logic [QW:0] twp_r, trp_r;
  logic [31:0] drop_r;

  logic [VOICES-1:0] act_r;
  logic [2:0]  vpad_r [VOICES];
  logic [POW-1:0] vpos_r [VOICES];
  logic [15:0] vgain_r [VOICES];

  logic [VW-1:0] vi_r;
  logic [2:0]  tpad_r;
  logic [22:0] gprod_r;
  logic [15:0] gain_new_r;
  logic [VW-1:0] slot_r;
  logic signed [16:0] sum_r;
  logic signed [32:0] p1_r;
  logic signed [48:0] p2_r;
  logic [POW-1:0] len_r;
  logic [15:0] ol_r, or_r;
  logic [CW-1:0] cnt_r;
  logic ov_r;

  function automatic logic [POW-1:0] eff_len(input logic [2:0] p);
    logic [13:0] l;
    l = '0;
    if (int'(p) < PADS && int'(p) < psvm_pkg::LEN_REGS) l = pad_len[p];
    if (32'(l) > PAD_SAMPLES) return POW'(PAD_SAMPLES);
    return POW'(l);
  endfunction

  logic fifo_full, fifo_empty;
  assign fifo_empty = (twp_r == trp_r);
  assign fifo_full  = (twp_r[QW] != trp_r[QW]) && (twp_r[QW-1:0] == trp_r[QW-1:0]);

  assign q_ready   = (st_r == S_IDLE) && !(ov_r && !out_ready);
  assign out_valid = ov_r;
  assign o_left    = ol_r;
  assign o_right   = or_r;
  assign o_active  = 5'(cnt_r);
  assign o_dropped = drop_r;

  logic [46:0] gq_prod;
  assign gq_prod = 47'(gprod_r) * 47'(RECIP_255);

  logic signed [48:0] term;
  logic signed [18:0] accv;
  always_comb begin
    term = p2_r >>> 29;
    if (p2_r < 0 && p2_r[28:0] != '0) term = term + 49'sd1;
    accv = 19'(sum_r) + 19'(term);
  end

  logic [MW-1:0] waddr, raddr;
  assign waddr = MW'(32'(q_item.pad) * PAD_SAMPLES + 32'(q_item.sample_address));
  assign raddr = MW'(32'(vpad_r[vi_r]) * PAD_SAMPLES + 32'(vpos_r[vi_r]));

  always_ff @(posedge clk) begin
    if (st_r == S_IDLE && q_valid && q_ready && q_item.func == psvm_pkg::FUNC_LOAD &&
        int'(q_item.pad) < PADS && 32'(q_item.sample_address) < PAD_SAMPLES)
      smem[waddr] <= q_item.sample_value;
    srd_r <= smem[raddr];
    if (st_r == S_IDLE && q_valid && q_ready && q_item.func == psvm_pkg::FUNC_TRIGGER &&
        !fifo_full)
      tq[twp_r[QW-1:0]] <= {q_item.pad, q_item.velocity};
    tq_rd_r <= tq[trp_r[QW-1:0]];
  end

  // Find first idle voice, voice 0 when all are busy.
  logic [VW-1:0] free_idx;
  always_comb begin
    free_idx = '0;
    for (int i = VOICES - 1; i >= 0; i--)
      if (!act_r[i]) free_idx = VW'(i);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; twp_r <= '0; trp_r <= '0; drop_r <= '0;
      act_r <= '0; ov_r <= 1'b0; vi_r <= '0; cnt_r <= '0;
      for (int i = 0; i < VOICES; i++) begin
        vpad_r[i] <= '0; vpos_r[i] <= '0; vgain_r[i] <= '0;
      end
    end else begin
      if (ov_r && out_ready) ov_r <= 1'b0;
      case (st_r)
        S_IDLE: begin
          if (q_valid && q_ready) begin
            case (q_item.func)
              psvm_pkg::FUNC_TRIGGER: begin
                if (int'(q_item.pad) < PADS) begin
                  if (fifo_full) begin
                    if (drop_r != '1) drop_r <= drop_r + 32'd1;
                  end else twp_r <= twp_r + (QW+1)'(1);
                end
              end
              psvm_pkg::FUNC_TICK: st_r <= S_DRAIN;
              default: ;
            endcase
          end
        end
        S_DRAIN: begin
          // Read data for the head entry is registered and ready in the following state, S_TRIG.
          if (fifo_empty) begin
            vi_r <= '0; sum_r <= '0; cnt_r <= '0; st_r <= S_VOICE;
          end else st_r <= S_TRIG;
        end
        S_TRIG: begin
          trp_r <= trp_r + (QW+1)'(1);
          tpad_r <= tq_rd_r[10:8];
          gprod_r <= 23'(GAIN_SPAN_EXT) * 23'(tq_rd_r[7:0]);
          if (int'(tq_rd_r[10:8]) < PADS && eff_len(tq_rd_r[10:8]) != '0) st_r <= S_GAIN;
          else st_r <= S_DRAIN;
        end
        S_GAIN: begin
          gain_new_r <= psvm_pkg::GAIN_BASE + 16'(gq_prod >> 31);
          slot_r <= free_idx;
          st_r <= S_FIND;
        end
        S_FIND: begin
          act_r[slot_r] <= 1'b1;
          vpad_r[slot_r] <= tpad_r;
          vpos_r[slot_r] <= '0;
          vgain_r[slot_r] <= gain_new_r;
          st_r <= S_DRAIN;
        end
        S_VOICE: begin
          if (act_r[vi_r]) begin
            len_r <= eff_len(vpad_r[vi_r]);
            if (vpos_r[vi_r] >= eff_len(vpad_r[vi_r])) begin
              act_r[vi_r] <= 1'b0;
              st_r <= S_ACC;
            end else st_r <= S_RD;
          end else st_r <= S_ACC;
        end
        S_RD: st_r <= S_MUL1;
        S_MUL1: begin
          p1_r <= 33'(signed'(srd_r)) * signed'({1'b0, vgain_r[vi_r]});
          st_r <= S_MUL2;
        end
        S_MUL2: begin
          p2_r <= 49'(p1_r) * signed'({1'b0, master_gain});
          st_r <= S_OUT;
        end
        S_OUT: begin
          if (accv > 19'sd32767) sum_r <= 17'sd32767;
          else if (accv < -19'sd32768) sum_r <= -17'sd32768;
          else sum_r <= 17'(accv);
          vpos_r[vi_r] <= vpos_r[vi_r] + POW'(1);
          if (vpos_r[vi_r] + POW'(1) >= len_r) act_r[vi_r] <= 1'b0;
          else cnt_r <= cnt_r + CW'(1);
          st_r <= S_ACC;
        end
        S_ACC: begin
          if (32'(vi_r) == VOICES - 1) begin
            ol_r <= sum_r[15:0];
            or_r <= stereo_mode ? sum_r[15:0] : 16'd0;
            ov_r <= 1'b1;
            vi_r <= '0;
            st_r <= S_IDLE;
          end else begin
            vi_r <= vi_r + VW'(1);
            st_r <= S_VOICE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

endmodule

/* design/polyphonic_sample_voice_mixer.sv */
// Channel | Signals                      | Contents
// in      | in_tvalid/in_tready/in_tdata | func, pad, velocity, sample_address, sample_value
// out     | out_tvalid/out_tready/out_tdata | left, right, active_voices, dropped_count
// cfg     | cfg_we/cfg_index/cfg_data    | register writes
// Load and trigger requests pass the four-entry item queue and are taken while
// the back part is idle. A tick drains the trigger queue: S_DRAIN, S_TRIG,
// S_GAIN, S_FIND for a trigger that starts a voice, S_DRAIN, S_TRIG for one on
// an empty pad, until S_DRAIN sees it empty; it then walks every voice: S_VOICE,
// S_RD, S_MUL1, S_MUL2, S_OUT, S_ACC for a playing voice, S_VOICE, S_ACC for an
// idle one (one sample memory port and the two registered multipliers set these
// steps). Reset is synchronous and clears control state; sample memory is not
// cleared. The input keeps accepting into the item queue while a result waits.
module polyphonic_sample_voice_mixer #(
  parameter int VOICES      = 16,
  parameter int PADS        = 5,
  parameter int QUEUE_DEPTH = 64,
  parameter int PAD_SAMPLES = 8192
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // func[1:0], pad[4:2], velocity[12:5], sample_address[25:13], sample_value[41:26]
  input  logic [47:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // left[15:0], right[31:16], active_voices[36:32], dropped_count[68:37]
  output logic [71:0] out_tdata,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [15:0] master_r;
  logic        stereo_r;
  logic [13:0] len_r [psvm_pkg::LEN_REGS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      master_r <= 16'd16384;
      stereo_r <= 1'b0;
      for (int i = 0; i < psvm_pkg::LEN_REGS; i++) len_r[i] <= '0;
    end else if (cfg_we) begin
      if (cfg_index == psvm_pkg::REG_MASTER) master_r <= cfg_data;
      else if (cfg_index == psvm_pkg::REG_STEREO) stereo_r <= cfg_data[0];
      else if (int'(cfg_index) < 2 + psvm_pkg::LEN_REGS)
        len_r[cfg_index - psvm_pkg::REG_LEN0] <= cfg_data[13:0];
    end
  end

  psvm_pkg::item_t in_item, q_item;
  logic q_valid, q_ready;
  assign in_item = {in_tdata[1:0], in_tdata[4:2], in_tdata[12:5], in_tdata[25:13],
                    in_tdata[41:26]};

  psvm_front #(.DEPTH(4)) u_front (
    .clk, .rst_n, .in_valid(in_tvalid), .in_ready(in_tready), .in_item,
    .q_valid, .q_ready, .q_item
  );

  logic [15:0] ol, orr;
  logic [4:0]  oa;
  logic [31:0] od;

  psvm_back #(.VOICES(VOICES), .PADS(PADS), .QUEUE_DEPTH(QUEUE_DEPTH),
              .PAD_SAMPLES(PAD_SAMPLES)) u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_item,
    .master_gain(master_r), .stereo_mode(stereo_r), .pad_len(len_r),
    .out_valid(out_tvalid), .out_ready(out_tready),
    .o_left(ol), .o_right(orr), .o_active(oa), .o_dropped(od)
  );

  assign out_tdata = {3'd0, od, oa, orr, ol};

endmodule

/* design/psvm_checker.sv */
module psvm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_act: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[36:32] <= 5'd16)
    else $error("active voice count out of range");

  a_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready ##1 out_tvalid |-> out_tdata[68:37] >= $past(out_tdata[68:37]))
    else $error("drop count decreased");

endmodule

bind polyphonic_sample_voice_mixer psvm_checker u_chk (
  .clk, .rst_n, .out_tvalid, .out_tready, .out_tdata
);

/* bench/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NVOICE = 16;
  localparam int NPAD = 5;
  localparam int QDEPTH = 64;
  localparam int REGION = 8192;
  localparam int IDLE_LIMIT = 20000;

  typedef struct packed {
    logic [31:0] dropped;
    logic [4:0]  active;
    logic [15:0] right;
    logic [15:0] left;
  } frame_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  polyphonic_sample_voice_mixer DUT (.*);

  always #5 clk = ~clk;

  // Predictor state.
  logic [15:0] m_master;
  logic        m_stereo;
  logic [13:0] m_len [NPAD];
  logic signed [15:0] m_store [NPAD*REGION];
  logic        v_on [NVOICE];
  logic [2:0]  v_pad [NVOICE];
  logic [13:0] v_pos [NVOICE];
  logic [15:0] v_gain [NVOICE];
  logic [10:0] m_fifo [$];
  logic [31:0] m_drops;

  psvm_pkg::item_t pending [$];
  frame_t frames_due [$];
  int     errors = 0;
  bit     quiet = 1'b0;     // no idling on either side
  bit     hold_out = 1'b0;  // long receiver hold-off
  bit     in_fire = 1'b0;   // a request was accepted at the last rising edge
  int     idle_cycles = 0;

  function automatic int eff_len(input int p);
    int l;
    l = m_len[p];
    return (l > REGION) ? REGION : l;
  endfunction

  function automatic void start_voice(input logic [2:0] p, input logic [7:0] vel);
    int k;
    k = 0;
    for (int i = NVOICE - 1; i >= 0; i--) if (!v_on[i]) k = i;
    v_on[k] = 1'b1;
    v_pad[k] = p;
    v_pos[k] = '0;
    v_gain[k] = 16'(13107 + (19661 * int'(vel)) / 255);
  endfunction

  function automatic void predict_request(input psvm_pkg::item_t it);
    logic [10:0] e;
    longint term, acc;
    int sum, cnt, len;
    frame_t f;
    case (it.func)
      psvm_pkg::FUNC_LOAD: if (it.pad < NPAD)
        m_store[it.pad*REGION + it.sample_address] = it.sample_value;
      psvm_pkg::FUNC_TRIGGER: if (it.pad < NPAD) begin
        if (m_fifo.size() >= QDEPTH) begin
          if (m_drops != 32'hFFFF_FFFF) m_drops++;
        end else m_fifo.push_back({it.pad, it.velocity});
      end
      psvm_pkg::FUNC_TICK: begin
        while (m_fifo.size() > 0) begin
          e = m_fifo.pop_front();
          if (e[10:8] < NPAD && eff_len(e[10:8]) != 0) start_voice(e[10:8], e[7:0]);
        end
        sum = 0;
        for (int i = 0; i < NVOICE; i++) begin
          if (!v_on[i]) continue;
          len = (v_pad[i] < NPAD) ? eff_len(v_pad[i]) : 0;
          if (v_pos[i] >= len) begin
            v_on[i] = 1'b0;
            continue;
          end
          term = longint'(m_store[v_pad[i]*REGION + v_pos[i]]) * longint'(v_gain[i])
                 * longint'(m_master);
          term = term / 536870912;
          acc = sum + term;
          if (acc > 32767) acc = 32767;
          if (acc < -32768) acc = -32768;
          sum = int'(acc);
          v_pos[i]++;
          if (v_pos[i] >= len) v_on[i] = 1'b0;
        end
        cnt = 0;
        for (int i = 0; i < NVOICE; i++) if (v_on[i]) cnt++;
        f.left = sum[15:0];
        f.right = m_stereo ? sum[15:0] : 16'd0;
        f.active = 5'(cnt);
        f.dropped = m_drops;
        frames_due.push_back(f);
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  // Driver.
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_fire) begin
        predict_request(pending.pop_front());
      end
      if (pending.size() > 0 && (quiet || $urandom_range(99) >= 33)) begin
        in_tvalid <= 1'b1;
        in_tdata <= {6'd0, pending[0].sample_value, pending[0].sample_address,
                     pending[0].velocity, pending[0].pad, pending[0].func};
      end else in_tvalid <= 1'b0;
      out_tready <= !hold_out && (quiet || $urandom_range(99) >= 33);
    end
  end

  // Monitor. The input handshake is captured here, since in_tready may
  // already have moved by the following falling edge.
  always @(posedge clk) begin
    frame_t got, want;
    in_fire <= rst_n && in_tvalid && in_tready;
    if (rst_n) begin
      idle_cycles <= ((in_tvalid && in_tready) || (out_tvalid && out_tready)) ? 0
                     : idle_cycles + 1;
      if (out_tvalid && out_tready) begin
        got = out_tdata[68:0];
        if (frames_due.size() == 0) report_mismatch("frame with nothing expected");
        else begin
          want = frames_due.pop_front();
          if (got.left !== want.left)
            report_mismatch($sformatf("left %0d want %0d", $signed(got.left),
                                      $signed(want.left)));
          if (got.right !== want.right)
            report_mismatch($sformatf("right %0d want %0d", $signed(got.right),
                                      $signed(want.right)));
          if (got.active !== want.active)
            report_mismatch($sformatf("active %0d want %0d", got.active, want.active));
          if (got.dropped !== want.dropped)
            report_mismatch($sformatf("dropped %0d want %0d", got.dropped, want.dropped));
        end
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("polyphonic_sample_voice_mixer regression: fail");
        $finish;
      end
    end
  end

  function automatic psvm_pkg::item_t mk(input logic [1:0] fn, input logic [2:0] p,
                                         input logic [7:0] vel, input logic [12:0] a,
                                         input logic [15:0] v);
    psvm_pkg::item_t it;
    it.func = fn; it.pad = p; it.velocity = vel; it.sample_address = a;
    it.sample_value = v;
    return it;
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      psvm_pkg::REG_MASTER: m_master = val;
      psvm_pkg::REG_STEREO: m_stereo = val[0];
      default: m_len[idx - psvm_pkg::REG_LEN0] = val[13:0];
    endcase
  endtask

  task automatic wait_idle();
    while (pending.size() > 0 || frames_due.size() > 0 || in_tvalid) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  // Short pads keep voices turning over; every sample a voice can reach is loaded.
  int plen [NPAD] = '{40, 25, 60, 12, 33};

  task automatic fill_pads();
    for (int p = 0; p < NPAD; p++)
      for (int a = 0; a < plen[p]; a++)
        pending.push_back(mk(psvm_pkg::FUNC_LOAD, 3'(p), 8'($urandom), 13'(a),
                             16'($urandom)));
    // Extremes of address and value, also address at the region top.
    pending.push_back(mk(psvm_pkg::FUNC_LOAD, 3'd4, 8'hFF, 13'h1FFF, 16'h8000));
    pending.push_back(mk(psvm_pkg::FUNC_LOAD, 3'd0, 8'h00, 13'd0, 16'h7FFF));
    pending.push_back(mk(psvm_pkg::FUNC_LOAD, 3'd1, 8'h00, 13'd1, 16'h8000));
  endtask

  task automatic random_phase(input int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 40)
        pending.push_back(mk(psvm_pkg::FUNC_TRIGGER, 3'($urandom_range(NPAD - 1)),
                             8'($urandom), 13'($urandom), 16'($urandom)));
      else if (r < 80) pending.push_back(mk(psvm_pkg::FUNC_TICK, 3'($urandom),
                                            8'($urandom), 13'($urandom), 16'($urandom)));
      else if (r < 88) pending.push_back(mk(psvm_pkg::FUNC_UNUSED, 3'($urandom),
                                            8'($urandom), 13'($urandom), 16'($urandom)));
      else if (r < 94) pending.push_back(mk(psvm_pkg::FUNC_TRIGGER,
                                            3'($urandom_range(7, 5)), 8'($urandom),
                                            13'($urandom), 16'($urandom)));
      else begin
        r = $urandom_range(NPAD - 1);
        pending.push_back(mk(psvm_pkg::FUNC_LOAD, 3'(r), 8'($urandom),
                             13'($urandom_range(plen[r] - 1)), 16'($urandom)));
      end
    end
    wait_idle();
  endtask

  initial begin
    m_master = 16'd16384;
    m_stereo = 1'b0;
    m_drops = '0;
    for (int i = 0; i < NPAD; i++) m_len[i] = '0;
    for (int i = 0; i < NVOICE; i++) begin
      v_on[i] = 1'b0; v_pad[i] = '0; v_pos[i] = '0; v_gain[i] = '0;
    end
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty pads, ignored pads, unused code, then loads.
    pending.push_back(mk(psvm_pkg::FUNC_TRIGGER, 3'd0, 8'd255, 13'd0, 16'd0));
    pending.push_back(mk(psvm_pkg::FUNC_TRIGGER, 3'd7, 8'd0, 13'd0, 16'd0));
    pending.push_back(mk(psvm_pkg::FUNC_LOAD, 3'd5, 8'd0, 13'd0, 16'd1));
    pending.push_back(mk(psvm_pkg::FUNC_UNUSED, 3'd0, 8'd0, 13'd0, 16'd0));
    pending.push_back(mk(psvm_pkg::FUNC_TICK, 3'd0, 8'd0, 13'd0, 16'd0));
    fill_pads();
    wait_idle();
    for (int p = 0; p < NPAD; p++) write_reg(psvm_pkg::REG_LEN0 + 3'(p), 16'(plen[p]));
    write_reg(psvm_pkg::REG_MASTER, 16'hFFFF);
    write_reg(psvm_pkg::REG_STEREO, 16'd1);
    // Directed triggers: velocity extremes, more than all voices, then ticks.
    for (int i = 0; i < 18; i++)
      pending.push_back(mk(psvm_pkg::FUNC_TRIGGER, 3'(i % NPAD), (i % 2) ? 8'd255 : 8'd0,
                           13'd0, 16'd0));
    for (int i = 0; i < 6; i++)
      pending.push_back(mk(psvm_pkg::FUNC_TICK, 3'd0, 8'd0, 13'd0, 16'd0));
    wait_idle();

    // Shrink a pad while voices play on it.
    pending.push_back(mk(psvm_pkg::FUNC_TRIGGER, 3'd2, 8'd128, 13'd0, 16'd0));
    pending.push_back(mk(psvm_pkg::FUNC_TICK, 3'd0, 8'd0, 13'd0, 16'd0));
    pending.push_back(mk(psvm_pkg::FUNC_TICK, 3'd0, 8'd0, 13'd0, 16'd0));
    wait_idle();
    write_reg(psvm_pkg::REG_LEN0 + 3'd2, 16'd1);
    pending.push_back(mk(psvm_pkg::FUNC_TICK, 3'd0, 8'd0, 13'd0, 16'd0));
    wait_idle();
    write_reg(psvm_pkg::REG_LEN0 + 3'd2, 16'd60);

    // FIFO overflow: 70 triggers with the receiver held off.
    for (int i = 0; i < 70; i++)
      pending.push_back(mk(psvm_pkg::FUNC_TRIGGER, 3'($urandom_range(NPAD - 1)),
                           8'($urandom), 13'd0, 16'd0));
    for (int i = 0; i < 30; i++)
      pending.push_back(mk(psvm_pkg::FUNC_TICK, 3'd0, 8'd0, 13'd0, 16'd0));
    hold_out = 1'b1;
    repeat (3000) @(posedge clk);
    hold_out = 1'b0;
    wait_idle();

    write_reg(psvm_pkg::REG_MASTER, 16'd0);
    write_reg(psvm_pkg::REG_STEREO, 16'd0);
    random_phase(100);
    write_reg(psvm_pkg::REG_MASTER, 16'd16384);
    write_reg(psvm_pkg::REG_LEN0 + 3'd0, 16'd0);
    quiet = 1'b1;
    random_phase(130);
    quiet = 1'b0;
    write_reg(psvm_pkg::REG_LEN0 + 3'd0, 16'd40);
    write_reg(psvm_pkg::REG_MASTER, 16'($urandom));
    write_reg(psvm_pkg::REG_STEREO, 16'd1);
    random_phase(150);
    write_reg(psvm_pkg::REG_MASTER, 16'hFFFF);
    random_phase(120);

    if (errors == 0) $display("polyphonic_sample_voice_mixer regression: pass");
    else $display("polyphonic_sample_voice_mixer regression: fail");
    $finish;
  end
endmodule
